// ===== rtl/core/shell_sort_keyed_records_top_macros.svh =====
// assertion macros for the keyed record sorter
`ifndef SHELL_SORT_KEYED_RECORDS_TOP_MACROS_SVH
`define SHELL_SORT_KEYED_RECORDS_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// checked only while out of reset
`define SSKR_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define SSKR_ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define SSKR_ASSERT(name, prop, msg)
`define SSKR_ASSERT_RST(name, prop, msg)
`endif

`endif

// ===== rtl/core/sskr_pkg.sv =====
`timescale 1ns / 1ps

package sskr_pkg;

    localparam int MAX_RECORDS_DEF = 32;

    localparam int KEY_W  = 16;
    localparam int TAG_W  = 8;
    localparam int WORD_W = KEY_W + TAG_W;
    localparam int MODE_W = 2;

    // order mode codes
    localparam logic [MODE_W-1:0] MODE_ASC  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DESC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_KEEP = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic load_accept;  // record transaction taken on the input
        logic start_sort;   // gap from half the fill count
        logic gap_next;     // halve the gap
        logic set_i;        // outer index from the gap
        logic rd_i;         // read entry i
        logic hold;         // capture held record, j from i
        logic rd_prev;      // read entry j - gap
        logic shift_wr;     // move entry j - gap up to j
        logic put_wr;       // drop held record at j, advance i
        logic out_load;     // load output register from read data
        logic clear_set;    // set emitted, back to empty
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic sort_on;
        logic gap_zero;
        logic i_end;
        logic j_ge_gap;
        logic must_shift;
        logic emit_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/core/sskr_dp.sv =====
`timescale 1ns / 1ps

module sskr_dp #(
    parameter int MAX_RECORDS = sskr_pkg::MAX_RECORDS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [sskr_pkg::MODE_W-1:0] i_cfg_data,
    input  logic [sskr_pkg::KEY_W-1:0]  i_key,
    input  logic [sskr_pkg::TAG_W-1:0]  i_tag,
    input  sskr_pkg::t_dp_cmd           i_cmd,
    output sskr_pkg::t_dp_sts           o_sts,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [sskr_pkg::KEY_W-1:0]  o_out_key,
    output logic [sskr_pkg::TAG_W-1:0]  o_out_tag,
    output logic                        o_out_last,
    output logic                        o_out_overflow
);

    localparam int AW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int KW = sskr_pkg::KEY_W;
    localparam int WW = sskr_pkg::WORD_W;

    // record store, word is {tag, key}
    logic [WW-1:0] r_mem [MAX_RECORDS];

    logic [CW-1:0] r_fill, r_gap, r_i, r_j, r_k;
    logic          r_dropped;
    logic [sskr_pkg::MODE_W-1:0] r_mode;
    logic [WW-1:0] r_held;
    logic [WW-1:0] r_rd;
    logic          r_out_valid;
    logic [WW-1:0] r_out_word;
    logic          r_out_last;
    logic          r_out_ovf;

    logic [CW-1:0] w_prev_idx;
    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_wr_addr;
    logic [WW-1:0] w_wr_data;
    logic          w_we;
    logic          w_full;
    logic          w_desc;

    assign w_prev_idx = r_j - r_gap;
    assign w_full     = (r_fill == CW'(MAX_RECORDS));
    assign w_desc     = (r_mode == sskr_pkg::MODE_DESC);

    always_comb begin
        if (i_cmd.rd_i) begin
            w_rd_addr = r_i[AW-1:0];
        end else if (i_cmd.rd_prev) begin
            w_rd_addr = w_prev_idx[AW-1:0];
        end else begin
            w_rd_addr = r_k[AW-1:0];
        end
    end

    assign w_we      = (i_cmd.load_accept && !w_full) || i_cmd.shift_wr || i_cmd.put_wr;
    assign w_wr_addr = i_cmd.load_accept ? r_fill[AW-1:0] : r_j[AW-1:0];

    always_comb begin
        if (i_cmd.load_accept) begin
            w_wr_data = {i_tag, i_key};
        end else if (i_cmd.shift_wr) begin
            w_wr_data = r_rd;
        end else begin
            w_wr_data = r_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd <= r_mem[w_rd_addr];
    end

    assign o_sts.sort_on    = (r_mode == sskr_pkg::MODE_ASC) || w_desc;
    assign o_sts.gap_zero   = (r_gap == '0);
    assign o_sts.i_end      = (r_i == r_fill);
    assign o_sts.j_ge_gap   = (r_j >= r_gap);
    assign o_sts.must_shift = w_desc ? (r_rd[KW-1:0] < r_held[KW-1:0])
                                     : (r_rd[KW-1:0] > r_held[KW-1:0]);
    assign o_sts.emit_last  = (CW'(r_k + CW'(1)) == r_fill);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    // sort indices and held record
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_sort) begin
            r_gap <= r_fill >> 1;
        end else if (i_cmd.gap_next) begin
            r_gap <= r_gap >> 1;
        end
        if (i_cmd.set_i) begin
            r_i <= r_gap;
        end else if (i_cmd.put_wr) begin
            r_i <= r_i + CW'(1);
        end
        if (i_cmd.hold) begin
            r_held <= r_rd;
            r_j    <= r_i;
        end else if (i_cmd.shift_wr) begin
            r_j <= w_prev_idx;
        end
    end

    // set bookkeeping, mode and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_dropped   <= 1'b0;
            r_k         <= '0;
            r_mode      <= sskr_pkg::MODE_ASC;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            if (i_cmd.clear_set) begin
                r_fill    <= '0;
                r_dropped <= 1'b0;
            end else if (i_cmd.load_accept) begin
                if (w_full) begin
                    r_dropped <= 1'b1;
                end else begin
                    r_fill <= r_fill + CW'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.clear_set) begin
                r_k <= '0;
            end else if (i_cmd.out_load) begin
                r_k <= r_k + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_word <= r_rd;
            r_out_last <= o_sts.emit_last;
            r_out_ovf  <= r_dropped;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_key      = r_out_word[KW-1:0];
    assign o_out_tag      = r_out_word[WW-1:KW];
    assign o_out_last     = r_out_last;
    assign o_out_overflow = r_out_ovf;

endmodule

// ===== rtl/core/sskr_ctrl.sv =====
`timescale 1ns / 1ps

module sskr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    input  sskr_pkg::t_dp_sts i_sts,
    output sskr_pkg::t_dp_cmd o_cmd,
    output logic              o_in_ready
);

    typedef enum logic [10:0] {
        S_LOAD    = 11'b000_0000_0001,
        S_START   = 11'b000_0000_0010,
        S_GAP     = 11'b000_0000_0100,
        S_RD_I    = 11'b000_0000_1000,
        S_HOLD    = 11'b000_0001_0000,
        S_CHK     = 11'b000_0010_0000,
        S_CMP     = 11'b000_0100_0000,
        S_PUT     = 11'b000_1000_0000,
        S_EMIT_RD = 11'b001_0000_0000,
        S_EMIT_WR = 11'b010_0000_0000,
        S_SPARE   = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.load_accept = 1'b1;
                    if (i_in_last) begin
                        n_state = i_sts.sort_on ? S_START : S_EMIT_RD;
                    end
                end
            end
            S_START: begin
                o_cmd.start_sort = 1'b1;
                n_state          = S_GAP;
            end
            S_GAP: begin
                if (i_sts.gap_zero) begin
                    n_state = S_EMIT_RD;
                end else begin
                    o_cmd.set_i = 1'b1;
                    n_state     = S_RD_I;
                end
            end
            S_RD_I: begin
                if (i_sts.i_end) begin
                    o_cmd.gap_next = 1'b1;
                    n_state        = S_GAP;
                end else begin
                    o_cmd.rd_i = 1'b1;
                    n_state    = S_HOLD;
                end
            end
            S_HOLD: begin
                o_cmd.hold = 1'b1;
                n_state    = S_CHK;
            end
            S_CHK: begin
                if (i_sts.j_ge_gap) begin
                    o_cmd.rd_prev = 1'b1;
                    n_state       = S_CMP;
                end else begin
                    n_state = S_PUT;
                end
            end
            S_CMP: begin
                if (i_sts.must_shift) begin
                    o_cmd.shift_wr = 1'b1;
                    n_state        = S_CHK;
                end else begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                o_cmd.put_wr = 1'b1;
                n_state      = S_RD_I;
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_WR;
            end
            S_EMIT_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_sts.emit_last) begin
                        o_cmd.clear_set = 1'b1;
                        n_state         = S_LOAD;
                    end else begin
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_LOAD);

endmodule

// ===== rtl/core/shell_sort_keyed_records_top.sv =====
`timescale 1ns / 1ps
// Keyed record sorter. Records (16-bit key, 8-bit tag) stream in one per cycle
// and are stored until the record marked with tlast arrives; up to MAX_RECORDS
// are kept, later ones are dropped and every result of that set carries the
// overflow flag in tuser. The set is then Shell sorted by key (gaps n/2, n/4
// .. 1, strict-compare insertion per gap, so equal keys may still be reordered
// by the wider gaps) ascending or descending as order_mode says, or left in
// arrival order for modes 2 and 3, and streamed out with tlast on the final
// record. The sort runs on a store with one write port and a registered read
// port; a pass at gap g visits n - g elements, moving each entry that must
// pass the held record up by the gap before the held record is written back.
// Each result is read from the store and then loaded into the output register
// once that register is free. The input is held off from the last record
// until the final result is loaded into the output register. order_mode is
// written on the cfg channel, which is always ready; write it only while no
// set is in progress.

`include "shell_sort_keyed_records_top_macros.svh"

module shell_sort_keyed_records_top #(
    parameter int MAX_RECORDS = sskr_pkg::MAX_RECORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data,      // order_mode

    // record input
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // [15:0] key_value, [23:16] record_tag
    input  logic        i_s_axis_tlast,  // set_last

    // sorted output
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // [15:0] sorted_key, [23:16] sorted_tag
    output logic        o_m_axis_tlast,  // out_last
    output logic [0:0]  o_m_axis_tuser   // [0] overflow
);

    sskr_pkg::t_dp_cmd w_cmd;
    sskr_pkg::t_dp_sts w_sts;
    logic              w_overflow;

    // config register lives in the datapath and takes a write every cycle
    assign o_cfg_ready = 1'b1;

    sskr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_last  (i_s_axis_tlast),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_ready (o_s_axis_tready)
    );

    sskr_dp #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_key          (i_s_axis_tdata[15:0]),
        .i_tag          (i_s_axis_tdata[23:16]),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_out_ready    (i_m_axis_tready),
        .o_out_valid    (o_m_axis_tvalid),
        .o_out_key      (o_m_axis_tdata[15:0]),
        .o_out_tag      (o_m_axis_tdata[23:16]),
        .o_out_last     (o_m_axis_tlast),
        .o_out_overflow (w_overflow)
    );

    assign o_m_axis_tuser = w_overflow;

    // the last record of a set closes the input until the set is emitted
    `SSKR_ASSERT(a_last_closes_input, (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast) |=> !o_s_axis_tready, "input still open after last record")
    // loading the final result of a set reopens the input
    `SSKR_ASSERT(a_emit_end_reopens, (w_cmd.out_load && w_sts.emit_last) |=> o_s_axis_tready, "input not reopened after final result")
    // no record transaction taken while the sorter owns the store
    `SSKR_ASSERT(a_no_load_in_sort, w_cmd.load_accept |-> !(w_cmd.shift_wr || w_cmd.put_wr || w_cmd.out_load), "record taken during sort or emission")
    // reset empties the output register
    `SSKR_ASSERT_RST(a_reset_out_empty, !i_rst_n |=> !o_m_axis_tvalid, "output valid after reset")

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import sskr_pkg::*;

    localparam int SET_CAPACITY = MAX_RECORDS_DEF;
    // the register field is two bits wide, and the top code behaves like keep
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 12;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] key;
    } t_record;

    typedef struct {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic             last;
        logic             dropped;
    } t_sorted_out;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [MODE_W-1:0] cfg_data = '0;
    logic              s_valid = 1'b0;
    logic [23:0]       s_data = '0;
    logic              s_last = 1'b0;
    logic              m_ready = 1'b0;

    logic              o_cfg_ready;
    logic              o_s_axis_tready;
    logic              o_m_axis_tvalid;
    logic [23:0]       o_m_axis_tdata;
    logic              o_m_axis_tlast;
    logic [0:0]        o_m_axis_tuser;

    // predictor state
    t_record           loaded_set[$];
    logic              set_dropped = 1'b0;
    logic [MODE_W-1:0] order_model = MODE_ASC;
    t_sorted_out       expected_sorted_q[$];

    int mismatch_count = 0;
    int result_count = 0;
    int records_sent = 0;
    int burst_left = 0;
    bit sender_bursty = 1'b1;
    int rx_hold_left = 0;

    shell_sort_keyed_records_top u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < 40) $display("%0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic bit key_moves_past(input logic [KEY_W-1:0] prev,
                                          input logic [KEY_W-1:0] held, input bit desc);
        return desc ? (prev < held) : (prev > held);
    endfunction

    // shell sort with halving gaps, strict compare inside each gap pass
    function automatic void sort_loaded_set();
        int          n, gap, i, j;
        t_record     held;
        bit          desc;
        t_sorted_out res;
        n = loaded_set.size();
        desc = (order_model == MODE_DESC);
        if (order_model == MODE_ASC || order_model == MODE_DESC) begin
            for (gap = n / 2; gap > 0; gap = gap / 2) begin
                for (i = gap; i < n; i++) begin
                    held = loaded_set[i];
                    j = i;
                    while (j >= gap && key_moves_past(loaded_set[j-gap].key, held.key, desc)) begin
                        loaded_set[j] = loaded_set[j-gap];
                        j -= gap;
                    end
                    loaded_set[j] = held;
                end
            end
        end
        for (i = 0; i < n; i++) begin
            res.key = loaded_set[i].key;
            res.tag = loaded_set[i].tag;
            res.last = (i == n - 1);
            res.dropped = set_dropped;
            expected_sorted_q.push_back(res);
        end
        loaded_set.delete();
        set_dropped = 1'b0;
    endfunction

    // transaction monitor: predicts on accepted records, checks accepted results
    always @(posedge clk) begin
        t_sorted_out exp_res;
        if (rst_n) begin
            if (cfg_valid && o_cfg_ready) order_model = cfg_data;
            if (s_valid && o_s_axis_tready) begin
                if (loaded_set.size() < SET_CAPACITY) loaded_set.push_back(s_data);
                else set_dropped = 1'b1;
                if (s_last) sort_loaded_set();
            end
            if (o_m_axis_tvalid && m_ready) begin
                result_count++;
                if (expected_sorted_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d not expected: key %h tag %h",
                        result_count, o_m_axis_tdata[15:0], o_m_axis_tdata[23:16]));
                end else begin
                    exp_res = expected_sorted_q.pop_front();
                    if (o_m_axis_tdata[15:0] !== exp_res.key)
                        report_mismatch($sformatf("result %0d key %h, want %h", result_count,
                            o_m_axis_tdata[15:0], exp_res.key));
                    if (o_m_axis_tdata[23:16] !== exp_res.tag)
                        report_mismatch($sformatf("result %0d tag %h, want %h", result_count,
                            o_m_axis_tdata[23:16], exp_res.tag));
                    if (o_m_axis_tlast !== exp_res.last)
                        report_mismatch($sformatf("result %0d last %b, want %b", result_count,
                            o_m_axis_tlast, exp_res.last));
                    if (o_m_axis_tuser[0] !== exp_res.dropped)
                        report_mismatch($sformatf("result %0d overflow %b, want %b",
                            result_count, o_m_axis_tuser[0], exp_res.dropped));
                end
            end
        end
    end

    // receiver stall patterns, with a long hold-off on request
    initial begin
        int style, span, phase;
        phase = 0;
        forever begin
            style = $urandom_range(0, 3);
            span = $urandom_range(8, 64);
            repeat (span) begin
                @(posedge clk);
                phase++;
                if (rx_hold_left > 0) begin
                    m_ready <= 1'b0;
                    rx_hold_left--;
                end else begin
                    case (style)
                        0: m_ready <= 1'b1;
                        1: m_ready <= $urandom_range(0, 1);
                        2: m_ready <= ($urandom_range(0, 3) == 0);
                        default: m_ready <= (phase % 3 != 0);
                    endcase
                end
            end
        end
    end

    // one record transaction; valid stays high for a following record
    task automatic send_record(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                               input bit last);
        int gap;
        if (sender_bursty && burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        if (burst_left > 0) burst_left--;
        s_valid <= 1'b1;
        s_data <= {tag, key};
        s_last <= last;
        do @(posedge clk); while (!(s_valid && o_s_axis_tready));
        records_sent++;
    endtask

    // sender stops until every expected result is out and the block settles
    task automatic pause_until_drained();
        s_valid <= 1'b0;
        // let the monitor see the last accepted record first
        @(posedge clk);
        while (expected_sorted_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_order_mode(input logic [MODE_W-1:0] mode);
        pause_until_drained();
        cfg_valid <= 1'b1;
        cfg_data <= mode;
        do @(posedge clk); while (!(cfg_valid && o_cfg_ready));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random_set(input int n, input bit narrow_keys);
        int k;
        for (k = 0; k < n; k++)
            send_record(narrow_keys ? KEY_W'($urandom_range(0, 7)) : KEY_W'($urandom),
                        TAG_W'($urandom), k == n - 1);
    endtask

    // mode is ascending straight out of reset
    task automatic test_reset_mode();
        send_record(16'd300, 8'd1, 1'b0);
        send_record(16'd100, 8'd2, 1'b0);
        send_record(16'd200, 8'd3, 1'b1);
        pause_until_drained();
    endtask

    task automatic test_directed_orders();
        write_order_mode(MODE_ASC);
        send_record(16'hFFFF, 8'hFF, 1'b0);
        send_record(16'h0000, 8'h00, 1'b0);
        send_record(16'hAAAA, 8'h55, 1'b0);
        send_record(16'h5555, 8'hAA, 1'b1);
        // equal keys in a descending set, tags show where ties end up
        write_order_mode(MODE_DESC);
        send_record(16'd5, 8'd1, 1'b0);
        send_record(16'd9, 8'd2, 1'b0);
        send_record(16'd5, 8'd3, 1'b0);
        send_record(16'd5, 8'd4, 1'b0);
        send_record(16'd9, 8'd5, 1'b1);
        write_order_mode(MODE_KEEP);
        send_record(16'd7, 8'd10, 1'b0);
        send_record(16'd1, 8'd11, 1'b0);
        send_record(16'd4, 8'd12, 1'b1);
        // unused code leaves arrival order too
        write_order_mode(MODE_SPARE);
        send_record(16'd70, 8'd20, 1'b0);
        send_record(16'd10, 8'd21, 1'b0);
        send_record(16'd40, 8'd22, 1'b1);
        // set of one record
        write_order_mode(MODE_ASC);
        send_record(16'h1234, 8'h56, 1'b1);
        pause_until_drained();
    endtask

    // records past capacity are dropped, including a dropped last record
    task automatic test_set_overflow();
        write_order_mode(MODE_DESC);
        send_random_set(SET_CAPACITY + 2, 1'b0);
        write_order_mode(MODE_ASC);
        send_random_set(SET_CAPACITY, 1'b1);
        pause_until_drained();
    endtask

    // receiver holds off while sets keep coming so the input stalls
    task automatic test_output_backpressure();
        sender_bursty = 1'b0;
        rx_hold_left = 400;
        send_random_set(12, 1'b0);
        send_random_set(9, 1'b1);
        send_random_set(5, 1'b0);
        pause_until_drained();
        sender_bursty = 1'b1;
    endtask

    task automatic test_random_sets();
        int start_count, pick, n;
        start_count = records_sent;
        while (records_sent - start_count < 40) begin
            if ($urandom_range(0, 3) == 0)
                write_order_mode(MODE_W'($urandom_range(0, 3)));
            pick = $urandom_range(0, 9);
            if (pick < 7) n = $urandom_range(1, 8);
            else if (pick < 9) n = $urandom_range(9, SET_CAPACITY - 1);
            else n = $urandom_range(SET_CAPACITY, SET_CAPACITY + 4);
            sender_bursty = ($urandom_range(0, 3) != 0);
            send_random_set(n, $urandom_range(0, 2) == 0);
        end
        sender_bursty = 1'b1;
        pause_until_drained();
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_mode();
        test_directed_orders();
        test_set_overflow();
        test_output_backpressure();
        test_random_sets();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && expected_sorted_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
